[src/mrrp_pkg.sv]
// Shared types and constants for the Modbus range reply parser.
`default_nettype none
package mrrp_pkg;

	// Frame framing constants
	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0]  PAYLOAD_BYTES     = 8'h04;
	localparam logic [3:0]  POS_DIST_HIGH     = 4'd3;
	localparam logic [3:0]  POS_DIST_LOW      = 4'd4;
	localparam logic [3:0]  POS_CRC_FIRST     = 4'd7;
	localparam logic [3:0]  POS_AFTER_LEN     = 4'd3;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_HIGH_FIRST = 1'b1;

	typedef enum logic [1:0] {
		PH_ADDR = 2'd0,
		PH_FUNC = 2'd1,
		PH_LEN  = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] device_address;
		logic       crc_high_first;
	} cfg_t;

	typedef struct packed {
		logic [15:0] distance_mm;
		logic        out_of_range;
		logic        crc_ok;
	} result_t;

endpackage
`default_nettype wire

[src/mrrp_crc_byte.sv]
// One-byte CRC-16/MODBUS update, unrolled over the eight bit steps.
`default_nettype none
module mrrp_crc_byte (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);
	import mrrp_pkg::*;

	// Fold the byte in, then shift eight times with the reflected polynomial
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

[src/mrrp_frame_parser.sv]
// Frame state machine, CRC accumulator and result register.
`default_nettype none
module mrrp_frame_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mrrp_pkg::cfg_t   cfg,
	input  wire logic             byte_valid,
	input  wire logic [7:0]       byte_data,
	output logic                  advance,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output mrrp_pkg::result_t     result
);
	import mrrp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  count_q, count_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  dist_high_q, dist_high_d;
	logic [7:0]  dist_low_q, dist_low_d;
	logic [7:0]  crc_first_q, crc_first_d;
	logic [15:0] crc_seed;
	logic [15:0] crc_next;
	logic        emit;
	logic        step;
	logic [15:0] received;
	logic [15:0] distance;
	logic        out_valid_s2;
	result_t     result_s2;

	// Move on whenever the result register is free or being taken
	assign advance = !out_valid_s2 || !out_stall;
	assign step    = byte_valid && advance;

	// A new frame restarts the CRC from its initial value
	assign crc_seed = (phase_q == PH_ADDR) ? CRC_INIT : crc_q;

	mrrp_crc_byte u_crc (
		.crc_in  (crc_seed),
		.data    (byte_data),
		.crc_out (crc_next)
	);

	// Assemble the received CRC and distance for the last beat
	assign received = cfg.crc_high_first ? {crc_first_q, byte_data}
	                                     : {byte_data, crc_first_q};
	assign distance = {dist_high_q, dist_low_q};

	// Next state of the frame hunt
	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		crc_d       = crc_q;
		dist_high_d = dist_high_q;
		dist_low_d  = dist_low_q;
		crc_first_d = crc_first_q;
		emit        = 1'b0;
		unique case (phase_q)
			PH_ADDR: begin
				if (byte_data == cfg.device_address) begin
					crc_d   = crc_next;
					count_d = 4'd1;
					phase_d = PH_FUNC;
				end
			end
			PH_FUNC: begin
				if (byte_data == FUNC_READ_HOLDING) begin
					crc_d   = crc_next;
					count_d = 4'd2;
					phase_d = PH_LEN;
				end else begin
					phase_d = PH_ADDR;
				end
			end
			PH_LEN: begin
				if (byte_data == PAYLOAD_BYTES) begin
					crc_d   = crc_next;
					count_d = POS_AFTER_LEN;
					phase_d = PH_BODY;
				end else begin
					phase_d = PH_ADDR;
				end
			end
			PH_BODY: begin
				count_d = count_q + 4'd1;
				if (count_q < POS_CRC_FIRST) begin
					if (count_q == POS_DIST_HIGH) begin
						dist_high_d = byte_data;
					end else if (count_q == POS_DIST_LOW) begin
						dist_low_d = byte_data;
					end
					crc_d = crc_next;
				end else if (count_q == POS_CRC_FIRST) begin
					crc_first_d = byte_data;
				end else begin
					emit    = 1'b1;
					phase_d = PH_ADDR;
				end
			end
			default: phase_d = PH_ADDR;
		endcase
	end

	// Hold parser state between beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR;
			count_q <= 4'd0;
			crc_q   <= CRC_INIT;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			crc_q   <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			dist_high_q <= dist_high_d;
			dist_low_q  <= dist_low_d;
			crc_first_q <= crc_first_d;
		end
	end

	// Result register: load on the last frame beat, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			result_s2.distance_mm  <= distance;
			result_s2.out_of_range <= (distance == 16'd0);
			result_s2.crc_ok       <= (received == crc_q);
		end
	end

	assign out_valid = out_valid_s2;
	assign result    = result_s2;

endmodule
`default_nettype wire

[src/modbus_range_reply_parser.sv]
// Top level of the Modbus range reply parser.
//
// Usage: received serial bytes enter on the input channel (in_valid, in_stall,
// rx_byte), one byte per beat. The block hunts for a nine-byte read-holding
// reply from device_address (function 0x03, length 0x04, four payload bytes,
// two CRC bytes) and emits one result per complete frame on the output
// channel (out_valid, out_stall, distance_mm, out_of_range, crc_ok).
// A frame with a bad CRC still gives a result, with crc_ok low.
// Path: a taken byte waits in the input register and is parsed from there;
// the result register loads as the ninth byte is parsed and offers the
// result from there.
// Throughput: one byte per cycle unless a result waits under out_stall; the
// byte's CRC update is one unrolled eight-step unit ahead of the CRC register.
// Stall: while a result waits under out_stall, the byte in the input register
// is held and in_stall rises; bytes flow again once the result is taken.
// Reset: address hunt, CRC at 0xFFFF, device_address 1, crc_high_first 1.
// The user must write registers through cfg_we/cfg_index/cfg_wdata only
// while no frame byte is in flight; the block does not enforce this.
`default_nettype none
module modbus_range_reply_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [mrrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mrrp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     rx_byte,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [15:0]                         distance_mm,
	output logic                                out_of_range,
	output logic                                crc_ok
);
	import mrrp_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	result_t    result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= 8'h01;
			cfg_q.crc_high_first <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_wdata[7:0];
				CFG_CRC_HIGH_FIRST: cfg_q.crc_high_first <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Input register: refill when empty or when its byte moves on
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	mrrp_frame_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (valid_s1),
		.byte_data  (byte_s1),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result)
	);

	assign distance_mm  = result.distance_mm;
	assign out_of_range = result.out_of_range;
	assign crc_ok       = result.crc_ok;

endmodule
`default_nettype wire

[sim/modbus_range_reply_parser_test.sv]
// Self-checking testbench for the Modbus range reply parser: byte stream in, readings checked.
`default_nettype none
module modbus_range_reply_parser_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mrrp_pkg::*;

	localparam int BYTES_PER_PHASE = 320;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_PRINTED = 30;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            rx_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [15:0]           distance_mm;
	logic                  out_of_range;
	logic                  crc_ok;

	// bytes waiting to go out, readings waiting to come back
	logic [7:0] tx_bytes [$];
	result_t    expected_readings [$];

	// traffic shaping
	int send_idle_pct;
	int recv_idle_pct;
	logic send_hold;
	int hold_req = 0;
	int hold_seen;
	int hold_left;

	// predictor copy of the configuration and parse state
	logic [7:0]  dev_addr;
	logic        dev_hi_first;
	phase_t      rx_phase;
	logic [3:0]  rx_count;
	logic [15:0] rx_crc;
	logic [7:0]  rx_dist_hi;
	logic [7:0]  rx_dist_lo;
	logic [7:0]  rx_crc_first;

	// run statistics
	int mismatches = 0;
	int bytes_taken = 0;
	int readings_seen = 0;
	int good_crc_seen = 0;
	int oor_seen = 0;
	result_t want;

	modbus_range_reply_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.distance_mm  (distance_mm),
		.out_of_range (out_of_range),
		.crc_ok       (crc_ok)
	);

	always #5 clk = ~clk;

	// CRC-16/MODBUS, one byte, reflected
	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Advance the parse state by one received byte; queue a reading on the ninth frame byte
	task automatic parse_rx_byte(input logic [7:0] b);
		logic [3:0]  pos;
		logic [15:0] crc_rx;
		result_t     r;
		case (rx_phase)
			PH_ADDR: begin
				if (b == dev_addr) begin
					rx_crc = crc16_feed(CRC_INIT, b);
					rx_count = 4'd1;
					rx_phase = PH_FUNC;
				end
			end
			PH_FUNC: begin
				if (b == FUNC_READ_HOLDING) begin
					rx_crc = crc16_feed(rx_crc, b);
					rx_count = 4'd2;
					rx_phase = PH_LEN;
				end else begin
					rx_phase = PH_ADDR;
				end
			end
			PH_LEN: begin
				if (b == PAYLOAD_BYTES) begin
					rx_crc = crc16_feed(rx_crc, b);
					rx_count = POS_AFTER_LEN;
					rx_phase = PH_BODY;
				end else begin
					rx_phase = PH_ADDR;
				end
			end
			default: begin
				pos = rx_count;
				rx_count = rx_count + 4'd1;
				if (pos < POS_CRC_FIRST) begin
					if (pos == POS_DIST_HIGH)
						rx_dist_hi = b;
					else if (pos == POS_DIST_LOW)
						rx_dist_lo = b;
					rx_crc = crc16_feed(rx_crc, b);
				end else if (pos == POS_CRC_FIRST) begin
					rx_crc_first = b;
				end else begin
					crc_rx = dev_hi_first ? {rx_crc_first, b} : {b, rx_crc_first};
					r.distance_mm = {rx_dist_hi, rx_dist_lo};
					r.out_of_range = (r.distance_mm == 16'd0);
					r.crc_ok = (crc_rx == rx_crc);
					expected_readings.push_back(r);
					rx_phase = PH_ADDR;
				end
			end
		endcase
	endtask

	task automatic report_mismatch(input string field, input int got, input int exp_val);
		if (mismatches < MAX_PRINTED)
			$display("%0t reading %0d: %s is %0h, predicted %0h", $realtime, readings_seen,
				field, got, exp_val);
		mismatches++;
	endtask

	// Queue one reply frame; optionally damage the CRC or send its CRC bytes in the other order
	task automatic queue_frame(input logic [7:0] addr, input logic [15:0] distance,
		input logic [15:0] spare, input bit corrupt, input bit swap);
		logic [7:0]  body [7];
		logic [15:0] crc;
		body = '{addr, FUNC_READ_HOLDING, PAYLOAD_BYTES, distance[15:8], distance[7:0],
			spare[15:8], spare[7:0]};
		crc = CRC_INIT;
		foreach (body[i]) begin
			crc = crc16_feed(crc, body[i]);
			tx_bytes.push_back(body[i]);
		end
		if (corrupt)
			crc ^= 16'h0001 << $urandom_range(0, 15);
		if (dev_hi_first ^ swap) begin
			tx_bytes.push_back(crc[15:8]);
			tx_bytes.push_back(crc[7:0]);
		end else begin
			tx_bytes.push_back(crc[7:0]);
			tx_bytes.push_back(crc[15:8]);
		end
	endtask

	// Mostly well-formed frames with random content, the rest noise and broken frames
	task automatic queue_random_traffic(input int n_bytes);
		int start;
		int pick;
		logic [15:0] distance;
		logic [7:0] addr;
		start = tx_bytes.size();
		while (tx_bytes.size() - start < n_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				case ($urandom_range(0, 7))
					0: distance = 16'h0000;
					1: distance = 16'hFFFF;
					default: distance = 16'($urandom_range(0, 65535));
				endcase
				addr = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : dev_addr;
				queue_frame(addr, distance, 16'($urandom_range(0, 65535)),
					$urandom_range(0, 4) == 0, $urandom_range(0, 15) == 0);
			end else if (pick < 82) begin
				repeat ($urandom_range(1, 3))
					tx_bytes.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				tx_bytes.push_back(dev_addr);
				tx_bytes.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 96) begin
				tx_bytes.push_back(dev_addr);
				tx_bytes.push_back(FUNC_READ_HOLDING);
				tx_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				// cut a frame short; what follows is swallowed as its body
				tx_bytes.push_back(dev_addr);
				tx_bytes.push_back(FUNC_READ_HOLDING);
				tx_bytes.push_back(PAYLOAD_BYTES);
				repeat ($urandom_range(0, 5))
					tx_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DEVICE_ADDRESS)
			dev_addr = data;
		else
			dev_hi_first = data[0];
	endtask

	// Wait until every byte is taken and every reading is back, then let the pipeline empty
	task automatic settle();
		while (tx_bytes.size() != 0 || in_valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drive bytes from the pending queue; hold a beat until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else if (!in_valid || !in_stall) begin
			if (!send_hold && tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte <= tx_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result channel at random, or for a long stretch on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Check readings against the oldest prediction, then predict from the byte taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					report_mismatch("unexpected reading, distance_mm", distance_mm, 0);
				end else begin
					want = expected_readings.pop_front();
					if (distance_mm !== want.distance_mm)
						report_mismatch("distance_mm", distance_mm, want.distance_mm);
					if (out_of_range !== want.out_of_range)
						report_mismatch("out_of_range", out_of_range, want.out_of_range);
					if (crc_ok !== want.crc_ok)
						report_mismatch("crc_ok", crc_ok, want.crc_ok);
				end
				readings_seen++;
				if (crc_ok === 1'b1)
					good_crc_seen++;
				if (out_of_range === 1'b1)
					oor_seen++;
			end
			if (in_valid && !in_stall) begin
				parse_rx_byte(rx_byte);
				bytes_taken++;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DEVICE_ADDRESS;
		cfg_wdata <= '0;
		send_hold <= 1'b0;
		send_idle_pct = 35;
		recv_idle_pct = 74;
		dev_addr = 8'h01;
		dev_hi_first = 1'b1;
		rx_phase = PH_ADDR;
		rx_count = 4'd0;
		rx_crc = CRC_INIT;
		rx_dist_hi = 8'h00;
		rx_dist_lo = 8'h00;
		rx_crc_first = 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: noise, wrong function, wrong length, repeated address, edge distances
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(dev_addr);
		tx_bytes.push_back(8'h04);
		tx_bytes.push_back(dev_addr);
		tx_bytes.push_back(FUNC_READ_HOLDING);
		tx_bytes.push_back(8'h05);
		tx_bytes.push_back(dev_addr);
		tx_bytes.push_back(dev_addr);
		queue_frame(dev_addr, 16'h0000, 16'h0000, 1'b0, 1'b0);
		queue_frame(dev_addr, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_register(CFG_DEVICE_ADDRESS, 8'h00);
					write_register(CFG_CRC_HIGH_FIRST, {7'h55, 1'b0});
				end
				1: begin
					write_register(CFG_DEVICE_ADDRESS, 8'hFF);
					write_register(CFG_CRC_HIGH_FIRST, {7'h2A, 1'b1});
				end
				3: begin
					write_register(CFG_DEVICE_ADDRESS, 8'h01);
					write_register(CFG_CRC_HIGH_FIRST, 8'h01);
				end
				default: begin
					write_register(CFG_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
					write_register(CFG_CRC_HIGH_FIRST, 8'($urandom_range(0, 255)));
				end
			endcase
			if (ph == 2) begin
				send_idle_pct = 74;
				recv_idle_pct = 35;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			queue_random_traffic(BYTES_PER_PHASE);

			// pause the sender mid-stream until every reading is back
			if (ph == 1) begin
				while (tx_bytes.size() > BYTES_PER_PHASE / 2)
					@(posedge clk);
				send_hold <= 1'b1;
				@(posedge clk);
				while (in_valid || expected_readings.size() != 0)
					@(posedge clk);
				send_hold <= 1'b0;
			end

			// hold the result channel off while bytes keep coming, so the block backs up
			if (ph == 4) begin
				while (tx_bytes.size() > BYTES_PER_PHASE - 60)
					@(posedge clk);
				hold_req <= hold_req + 1;
			end
			settle();
		end

		if (expected_readings.size() != 0)
			report_mismatch("readings never returned", 0, expected_readings.size());
		$display("Sent %0d bytes over 7 settings of address and CRC order; checked %0d readings",
			bytes_taken, readings_seen);
		$display("(%0d with a good CRC, %0d out of range), %0d mismatches",
			good_crc_seen, oor_seen, mismatches);
		if (mismatches == 0)
			$display("[modbus_range_reply_parser] OK");
		else
			$display("[modbus_range_reply_parser] ERROR");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("Timed out with %0d readings outstanding", expected_readings.size());
		$display("[modbus_range_reply_parser] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
src/mrrp_pkg.sv
src/mrrp_crc_byte.sv
src/mrrp_frame_parser.sv
src/modbus_range_reply_parser.sv
sim/modbus_range_reply_parser_test.sv
